>>> hw/rtl/rc5_block_cipher_defines.svh
// assertion helpers shared by the rc5 files
`ifndef RC5_BLOCK_CIPHER_DEFINES_SVH
`define RC5_BLOCK_CIPHER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RC5_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RC5_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/rc5_pkg.sv
package rc5_pkg;

    localparam int ROUNDS      = 12;
    localparam int TABLE_WORDS = 2 * ROUNDS + 2;
    localparam int IDX_W       = $clog2(TABLE_WORDS);
    localparam int WORD_W      = 32;
    localparam int ROT_W       = 5;
    localparam int KEY_W       = 64;
    localparam int MIX_PASSES  = 3;

    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(TABLE_WORDS - 1);
    localparam logic [WORD_W-1:0] MAGIC_P  = 32'hb7e15163;
    localparam logic [WORD_W-1:0] MAGIC_Q  = 32'h9e3779b9;

    localparam logic [1:0] CMD_ENCRYPT = 2'd0;
    localparam logic [1:0] CMD_DECRYPT = 2'd1;
    localparam logic [1:0] CMD_EXPAND  = 2'd2;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [WORD_W-1:0] word_a;
        logic [WORD_W-1:0] word_b;
    } t_in;

    typedef struct packed {
        logic [WORD_W-1:0] result_a;
        logic [WORD_W-1:0] result_b;
    } t_out;

    typedef struct packed {
        logic             pre_xor;
        logic             post_add;
        logic [ROT_W-1:0] rot_amt;
    } t_alu_ctl;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [WORD_W-1:0] data;
    } t_ram_wr;

    function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
                                                 input logic [ROT_W-1:0]  n);
        logic [2*WORD_W-1:0] t;
        t = {x, x} << n;
        return t[2*WORD_W-1:WORD_W];
    endfunction

endpackage

>>> hw/rtl/rc5_alu.sv
module rc5_alu (
    input  rc5_pkg::t_alu_ctl           i_ctl,
    input  logic [rc5_pkg::WORD_W-1:0]  i_u,
    input  logic [rc5_pkg::WORD_W-1:0]  i_v,
    input  logic [rc5_pkg::WORD_W-1:0]  i_w,
    input  logic [rc5_pkg::WORD_W-1:0]  i_z,
    output logic [rc5_pkg::WORD_W-1:0]  o_y
);

    logic [rc5_pkg::WORD_W-1:0] pre;
    logic [rc5_pkg::WORD_W-1:0] rot;

    // xor or three-way add, rotate left, then add or xor
    always_comb begin
        pre = i_ctl.pre_xor ? (i_u ^ i_v) : (i_u + i_v + i_w);
        rot = rc5_pkg::rotl32(pre, i_ctl.rot_amt);
        o_y = i_ctl.post_add ? (rot + i_z) : (rot ^ i_z);
    end

endmodule

>>> hw/rtl/rc5_key_ram.sv
`include "rc5_block_cipher_defines.svh"

module rc5_key_ram (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rc5_pkg::t_ram_wr            i_wr,
    input  logic [rc5_pkg::IDX_W-1:0]   i_rd_addr,
    output logic [rc5_pkg::WORD_W-1:0]  o_rd_data
);

    logic [rc5_pkg::WORD_W-1:0] r_mem [rc5_pkg::TABLE_WORDS];
    logic [rc5_pkg::WORD_W-1:0] r_rd_data;
    logic                       r_filled;
    logic                       r_rd_ok;

    // the table is only ever written as a whole, so one flag stands for all entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= 1'b0;
            r_rd_ok  <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_filled <= 1'b1;
            end
            r_rd_ok <= r_filled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

    `RC5_ASSERT_IMPL(a_wr_rd_apart, i_wr.en, i_wr.addr != i_rd_addr, "write and read collide")
    `RC5_ASSERT_IMPL(a_wr_in_range, i_wr.en, i_wr.addr <= rc5_pkg::LAST_IDX, "write past table")
    `RC5_ASSERT_NEXT(a_fill_sticks, i_wr.en, r_filled, "fill flag not set after write")

endmodule

>>> hw/rtl/rc5_block_cipher.sv
// channel   direction  handshake              payload
// item      in         start high, busy low   i_item (cmd, word_a, word_b)
// result    out        o_strobe, one cycle    o_result (result_a, result_b)
// key       in         i_key_we               i_key_wdata (64 bits)
//
// encrypt/decrypt: one half-round per cycle through the shared add/rotate unit,
// result strobed in the cycle after the last step; the next item can be taken in the strobe cycle
// key expansion: ST_INIT fills the table; each mixing step runs ST_MIX_X then ST_MIX_Y, the last only ST_MIX_X
// unused command: result strobed the cycle after accept
// synchronous active-low reset clears the key and empties the round-key table
// results cannot be held off; o_strobe marks each beat for exactly one cycle
`include "rc5_block_cipher_defines.svh"

module rc5_block_cipher (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  rc5_pkg::t_in               i_item,
    output logic                       o_strobe,
    output rc5_pkg::t_out              o_result,
    input  logic                       i_key_we,
    input  logic [rc5_pkg::KEY_W-1:0]  i_key_wdata
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CRYPT = 5'b00010,
        ST_INIT  = 5'b00100,
        ST_MIX_X = 5'b01000,
        ST_MIX_Y = 5'b10000
    } t_state;

    localparam int WW = rc5_pkg::WORD_W;
    localparam int IW = rc5_pkg::IDX_W;
    localparam int RW = rc5_pkg::ROT_W;

    t_state                         r_state, n_state;
    logic [IW-1:0]                  r_idx, n_idx;
    logic [1:0]                     r_pass, n_pass;
    logic                           r_ki, n_ki;
    logic                           r_dec, n_dec;
    logic                           r_strobe, n_strobe;
    logic [WW-1:0]                  r_a, n_a;
    logic [WW-1:0]                  r_b, n_b;
    logic [WW-1:0]                  r_kw0, n_kw0;
    logic [WW-1:0]                  r_kw1, n_kw1;
    rc5_pkg::t_out                  r_out, n_out;
    logic [rc5_pkg::KEY_W-1:0]      r_secret_key;

    rc5_pkg::t_alu_ctl              alu_ctl;
    logic [WW-1:0]                  alu_u, alu_v, alu_w, alu_z, alu_y;
    rc5_pkg::t_ram_wr               ram_wr;
    logic [IW-1:0]                  rd_addr;
    logic [WW-1:0]                  rd_data;

    logic [IW-1:0]                  idx_inc, idx_dec;
    logic [WW-1:0]                  src, oth;
    logic                           first;
    logic                           last;

    rc5_alu u_alu (
        .i_ctl (alu_ctl),
        .i_u   (alu_u),
        .i_v   (alu_v),
        .i_w   (alu_w),
        .i_z   (alu_z),
        .o_y   (alu_y)
    );

    rc5_key_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (ram_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

    assign idx_inc = (r_idx == rc5_pkg::LAST_IDX) ? '0 : (r_idx + IW'(1));
    assign idx_dec = r_idx - IW'(1);
    // even steps update a, odd steps update b
    assign src     = r_idx[0] ? r_b : r_a;
    assign oth     = r_idx[0] ? r_a : r_b;
    assign first   = (r_idx < IW'(2));

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_pass   = r_pass;
        n_ki     = r_ki;
        n_dec    = r_dec;
        n_strobe = 1'b0;
        n_a      = r_a;
        n_b      = r_b;
        n_kw0    = r_kw0;
        n_kw1    = r_kw1;
        n_out    = r_out;
        last     = 1'b0;

        alu_ctl  = '0;
        alu_u    = r_a;
        alu_v    = '0;
        alu_w    = '0;
        alu_z    = '0;

        ram_wr.en   = 1'b0;
        ram_wr.addr = r_idx;
        ram_wr.data = r_a;
        rd_addr     = idx_inc;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_a   = i_item.word_a;
                    n_b   = i_item.word_b;
                    n_dec = (i_item.cmd == rc5_pkg::CMD_DECRYPT);
                    priority if (i_item.cmd == rc5_pkg::CMD_ENCRYPT) begin
                        n_state = ST_CRYPT;
                        n_idx   = '0;
                        rd_addr = '0;
                    end else if (i_item.cmd == rc5_pkg::CMD_DECRYPT) begin
                        n_state = ST_CRYPT;
                        n_idx   = rc5_pkg::LAST_IDX;
                        rd_addr = rc5_pkg::LAST_IDX;
                    end else if (i_item.cmd == rc5_pkg::CMD_EXPAND) begin
                        n_state = ST_INIT;
                        n_idx   = '0;
                        n_pass  = '0;
                        n_ki    = 1'b0;
                        n_a     = rc5_pkg::MAGIC_P;
                        n_b     = '0;
                        n_kw0   = r_secret_key[WW-1:0];
                        n_kw1   = r_secret_key[2*WW-1:WW];
                    end else begin
                        n_strobe = 1'b1;
                        n_out    = '0;
                    end
                end
            end

            ST_CRYPT: begin
                alu_u = src;
                if (!r_dec) begin
                    // x = rotl(x ^ y, y) + s, plain add for the whitening steps
                    alu_ctl.pre_xor  = 1'b1;
                    alu_ctl.post_add = 1'b1;
                    alu_ctl.rot_amt  = first ? '0 : oth[RW-1:0];
                    alu_v            = first ? '0 : oth;
                    alu_z            = rd_data;
                    rd_addr          = idx_inc;
                    n_idx            = idx_inc;
                    last             = (r_idx == rc5_pkg::LAST_IDX);
                end else begin
                    // x = rotr(x - s, y) ^ y, plain subtract for the whitening steps
                    alu_ctl.pre_xor  = 1'b0;
                    alu_ctl.post_add = 1'b0;
                    alu_ctl.rot_amt  = first ? '0 : (RW'(0) - oth[RW-1:0]);
                    alu_v            = ~rd_data;
                    alu_w            = WW'(1);
                    alu_z            = first ? '0 : oth;
                    rd_addr          = idx_dec;
                    n_idx            = idx_dec;
                    last             = (r_idx == '0);
                end
                if (r_idx[0]) begin
                    n_b = alu_y;
                end else begin
                    n_a = alu_y;
                end
                if (last) begin
                    n_state        = ST_IDLE;
                    n_strobe       = 1'b1;
                    n_out.result_a = r_idx[0] ? r_a : alu_y;
                    n_out.result_b = r_idx[0] ? alu_y : r_b;
                end
            end

            ST_INIT: begin
                // table fill: s[i] = p + i*q
                alu_u       = r_a;
                alu_v       = rc5_pkg::MAGIC_Q;
                ram_wr.en   = 1'b1;
                ram_wr.data = r_a;
                n_a         = alu_y;
                n_idx       = idx_inc;
                if (r_idx == rc5_pkg::LAST_IDX) begin
                    n_a     = '0;
                    n_state = ST_MIX_X;
                end
            end

            ST_MIX_X: begin
                alu_u           = rd_data;
                alu_v           = r_a;
                alu_w           = r_b;
                alu_ctl.rot_amt = RW'(3);
                ram_wr.en       = 1'b1;
                ram_wr.data     = alu_y;
                n_a             = alu_y;
                if (r_pass == 2'(rc5_pkg::MIX_PASSES - 1) &&
                    r_idx == rc5_pkg::LAST_IDX) begin
                    n_state  = ST_IDLE;
                    n_strobe = 1'b1;
                    n_out    = '0;
                end else begin
                    n_state = ST_MIX_Y;
                end
            end

            ST_MIX_Y: begin
                alu_u           = r_ki ? r_kw1 : r_kw0;
                alu_v           = r_a;
                alu_w           = r_b;
                alu_ctl.rot_amt = r_a[RW-1:0] + r_b[RW-1:0];
                n_b             = alu_y;
                if (r_ki) begin
                    n_kw1 = alu_y;
                end else begin
                    n_kw0 = alu_y;
                end
                n_ki    = ~r_ki;
                n_idx   = idx_inc;
                n_state = ST_MIX_X;
                if (r_idx == rc5_pkg::LAST_IDX) begin
                    n_pass = r_pass + 2'd1;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_idx        <= '0;
            r_pass       <= '0;
            r_ki         <= 1'b0;
            r_dec        <= 1'b0;
            r_strobe     <= 1'b0;
            r_secret_key <= '0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_pass   <= n_pass;
            r_ki     <= n_ki;
            r_dec    <= n_dec;
            r_strobe <= n_strobe;
            if (i_key_we) begin
                r_secret_key <= i_key_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_kw0 <= n_kw0;
        r_kw1 <= n_kw1;
        r_out <= n_out;
    end

    `RC5_ASSERT_IMPL(a_strobe_idle, o_strobe, !busy, "result beat while still working")
    `RC5_ASSERT_NEXT(a_expand_fill, start && !busy && i_item.cmd == rc5_pkg::CMD_EXPAND, r_state == ST_INIT, "expand did not start fill")
    `RC5_ASSERT_IMPL(a_idx_range, r_state != ST_IDLE, r_idx <= rc5_pkg::LAST_IDX, "table index out of range")

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rc5_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 1_000_000;
    localparam int         SETTLE_CYCLES = 40;
    localparam int         REKEY_EVERY = 64;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    t_in                i_item;
    logic               o_strobe;
    t_out               o_result;
    logic               i_key_we;
    logic [KEY_W-1:0]   i_key_wdata;

    // predictor state
    logic [WORD_W-1:0]  round_keys [TABLE_WORDS];
    logic [KEY_W-1:0]   key_shadow;
    t_out               expected_blocks [$];

    int                 mismatches;
    int                 cycle_count;
    int                 sender_idle_pct;

    rc5_block_cipher dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_key_we    (i_key_we),
        .i_key_wdata (i_key_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [WORD_W-1:0] rot_left(input logic [WORD_W-1:0] x,
                                                   input logic [ROT_W-1:0]  n);
        if (n == '0) begin
            return x;
        end
        return (x << n) | (x >> (WORD_W - int'(n)));
    endfunction

    function automatic logic [WORD_W-1:0] rot_right(input logic [WORD_W-1:0] x,
                                                    input logic [ROT_W-1:0]  n);
        if (n == '0) begin
            return x;
        end
        return (x >> n) | (x << (WORD_W - int'(n)));
    endfunction

    function automatic void rebuild_round_keys();
        logic [WORD_W-1:0] kw [2];
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        int                ti;
        int                ki;
        kw[0] = key_shadow[31:0];
        kw[1] = key_shadow[63:32];
        x = '0;
        y = '0;
        ti = 0;
        ki = 0;
        round_keys[0] = MAGIC_P;
        for (int s = 1; s < TABLE_WORDS; s++) begin
            round_keys[s] = round_keys[s-1] + MAGIC_Q;
        end
        for (int s = 0; s < MIX_PASSES * TABLE_WORDS; s++) begin
            x = rot_left(round_keys[ti] + x + y, ROT_W'(3));
            round_keys[ti] = x;
            y = rot_left(kw[ki] + x + y, ROT_W'(x + y));
            kw[ki] = y;
            ti = (ti + 1) % TABLE_WORDS;
            ki ^= 1;
        end
    endfunction

    // works out the result block of one command and applies its effect on the table
    function automatic t_out cipher_model(input t_in it);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        t_out              res;
        a = it.word_a;
        b = it.word_b;
        case (it.cmd)
            CMD_ENCRYPT: begin
                a = a + round_keys[0];
                b = b + round_keys[1];
                for (int r = 1; r <= ROUNDS; r++) begin
                    a = rot_left(a ^ b, b[ROT_W-1:0]) + round_keys[2*r];
                    b = rot_left(b ^ a, a[ROT_W-1:0]) + round_keys[2*r+1];
                end
            end
            CMD_DECRYPT: begin
                for (int r = ROUNDS; r > 0; r--) begin
                    b = rot_right(b - round_keys[2*r+1], a[ROT_W-1:0]) ^ a;
                    a = rot_right(a - round_keys[2*r], b[ROT_W-1:0]) ^ b;
                end
                b = b - round_keys[1];
                a = a - round_keys[0];
            end
            CMD_EXPAND: begin
                rebuild_round_keys();
                a = '0;
                b = '0;
            end
            default: begin
                a = '0;
                b = '0;
            end
        endcase
        res.result_a = a;
        res.result_b = b;
        return res;
    endfunction

    // result checking and prediction on each accepted beat
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (expected_blocks.size() == 0) begin
                    $display("%0t: result beat with none expected, got a=%h b=%h",
                             $time, o_result.result_a, o_result.result_b);
                    mismatches++;
                end else begin
                    want = expected_blocks.pop_front();
                    if (o_result.result_a !== want.result_a) begin
                        $display("%0t: result_a expected %h got %h",
                                 $time, want.result_a, o_result.result_a);
                        mismatches++;
                    end
                    if (o_result.result_b !== want.result_b) begin
                        $display("%0t: result_b expected %h got %h",
                                 $time, want.result_b, o_result.result_b);
                        mismatches++;
                    end
                end
            end
            if (i_key_we) begin
                key_shadow = i_key_wdata;
            end
            if (start && !busy) begin
                expected_blocks.push_back(cipher_model(i_item));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("rc5_block_cipher: timeout after %0d cycles", cycle_count);
            $display("rc5_block_cipher: mismatch");
            $finish;
        end
    end

    task automatic send_block(input logic [1:0] op, input logic [WORD_W-1:0] a,
                              input logic [WORD_W-1:0] b);
        t_in it;
        it.cmd = op;
        it.word_a = a;
        it.word_b = b;
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
    endtask

    // drop start and wait until every expected beat is in and the block is free
    task automatic drain();
        start <= 1'b0;
        @(negedge i_clk);
        while (expected_blocks.size() != 0 || busy) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
    endtask

    task automatic write_key(input logic [KEY_W-1:0] k);
        i_key_we <= 1'b1;
        i_key_wdata <= k;
        @(posedge i_clk);
        i_key_we <= 1'b0;
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(15))
            0: return '0;
            1: return '1;
            2: return 32'h8000_0000;
            3: return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // blocks run through the all-zero table left by reset
    task automatic test_reset_table();
        send_block(CMD_ENCRYPT, '0, '0);
        send_block(CMD_ENCRYPT, '1, '1);
        send_block(CMD_DECRYPT, '0, '1);
        send_block(CMD_DECRYPT, 32'haaaa_5555, 32'h5555_aaaa);
        send_block(CMD_UNUSED, '1, '1);
        send_block(CMD_UNUSED, '0, '0);
        drain();
    endtask

    task automatic test_key_extremes();
        logic [KEY_W-1:0] keys [3];
        keys[0] = '0;
        keys[1] = '1;
        keys[2] = 64'hefcd_ab89_6745_2301;
        foreach (keys[i]) begin
            write_key(keys[i]);
            // word fields of an expand are ignored
            send_block(CMD_EXPAND, '1, '1);
            send_block(CMD_ENCRYPT, '0, '0);
            send_block(CMD_ENCRYPT, '1, 32'h8000_0000);
            send_block(CMD_DECRYPT, '1, '1);
            send_block(CMD_DECRYPT, 32'h0000_0001, '0);
            drain();
        end
        send_block(CMD_UNUSED, 32'h1234_5678, 32'h9abc_def0);
        drain();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int n_items);
        int               pick;
        logic [1:0]       op;
        sender_idle_pct = idle_pct;
        for (int n = 0; n < n_items; n++) begin
            if (n % REKEY_EVERY == 0) begin
                drain();
                write_key(pick_key());
                send_block(CMD_EXPAND, $urandom, $urandom);
            end
            pick = $urandom_range(99);
            if (pick < 46) begin
                op = CMD_ENCRYPT;
            end else if (pick < 92) begin
                op = CMD_DECRYPT;
            end else if (pick < 96) begin
                op = CMD_EXPAND;
            end else begin
                op = CMD_UNUSED;
            end
            send_block(op, pick_word(), pick_word());
        end
        drain();
    endtask

    initial begin
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_item <= '0;
        i_key_we <= 1'b0;
        i_key_wdata <= '0;
        key_shadow = '0;
        foreach (round_keys[i]) begin
            round_keys[i] = '0;
        end
        mismatches = 0;
        cycle_count = 0;
        sender_idle_pct = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_table();
        test_key_extremes();
        test_random_traffic(0, 350);
        test_random_traffic(67, 350);
        test_random_traffic(9, 350);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_blocks.size() == 0) begin
            $display("rc5_block_cipher: match");
        end else begin
            $display("rc5_block_cipher: mismatch");
        end
        $finish;
    end

endmodule

>>> rc5_block_cipher.f
+incdir+hw/rtl
hw/rtl/rc5_pkg.sv
hw/rtl/rc5_alu.sv
hw/rtl/rc5_key_ram.sv
hw/rtl/rc5_block_cipher.sv
tb/sv/tb_top.sv
